### rtl/core/trfm_pkg.sv
package trfm_pkg;

  // Field widths fixed by the stream format
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int OP_W        = 2;
  localparam int NORM_W      = 16;
  localparam int TIME_IN_W   = 16;
  localparam int OPACITY_W   = 8;
  localparam int HOLD_OUT_W  = 16;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 32;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_TIMER_BITS = 16;

  localparam logic [OPACITY_W-1:0] OPAQUE     = 8'd255;
  localparam logic [CFG_W-1:0]     GRID_RESET = 9'd256;

  // Operation codes carried on s_tuser
  localparam logic [OP_W-1:0] OP_REVEAL = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAPX,
    ST_MAPY,
    ST_ADDR,
    ST_REVEAL,
    ST_TICK,
    ST_DRAIN,
    ST_PRB_RD,
    ST_PRB_WAIT,
    ST_DONE
  } state_t;

endpackage

### rtl/core/timed_reveal_fade_map.sv
// Pixel reveal/fade map. Each pixel keeps an 8-bit opacity and a hold timer in one
// MAX_WIDTH*MAX_HEIGHT entry RAM, addressed row*MAX_WIDTH + column. One item is taken
// at a time on s_*; op on s_tuser selects reveal, probe or tick. All work goes through
// one RAM read port, one write port and a single pixel update unit, one pixel per
// cycle. Reveal maps the position with one shared multiplier, then does up to five
// read-modify-writes; probe maps and reads one pixel; tick walks the columns in use
// times the rows in use; an unused op 3 goes straight to the result. A result that
// cannot leave because the m_* register is still full holds the block in ST_DONE
// until the sink takes it. After reset a clearing pass writes every RAM entry to
// opaque with zero hold, during which no item is accepted. Grid size writes on
// cfg_* are always taken, but must only come while no item is in flight.
// A finished result waits in the m_* output register while the next item is accepted.
module timed_reveal_fade_map #(
  parameter int MAX_WIDTH  = trfm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = trfm_pkg::DEF_MAX_HEIGHT,
  parameter int TIMER_BITS = trfm_pkg::DEF_TIMER_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // norm_x [15:0], norm_y [31:16], reveal_time [47:32]
  input  logic [trfm_pkg::S_TDATA_W-1:0] s_tdata,
  // op [1:0]
  input  logic [trfm_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // opacity [7:0], hold_left [23:8], changed [24], zero [31:25]
  output logic [trfm_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [trfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trfm_pkg::CFG_W-1:0]     cfg_data
);

  import trfm_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = TIMER_BITS + OPACITY_W;
  localparam int PW    = NORM_W + CFG_W;
  localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [31:0]   TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  localparam logic [2:0] SLOT_CENTER = 3'd0;
  localparam logic [2:0] SLOT_RIGHT  = 3'd1;
  localparam logic [2:0] SLOT_LEFT   = 3'd2;
  localparam logic [2:0] SLOT_DOWN   = 3'd3;
  localparam logic [2:0] SLOT_UP     = 3'd4;

  state_t state, state_next;

  logic [CFG_W-1:0]      grid_width, grid_height;
  logic [CFG_W-1:0]      w, h;
  logic [OP_W-1:0]       in_op;
  logic [NORM_W-1:0]     in_x, in_y;
  logic [TIMER_BITS-1:0] in_time;
  logic [31:0]           time_in32;
  logic [CFG_W-1:0]      px, py;
  logic [AW-1:0]         base_addr;
  logic [2:0]            slot;
  logic [CFG_W-1:0]      col, row;
  logic [AW-1:0]         row_base;
  logic                  col_last, row_last;
  logic [AW-1:0]         clr_addr;
  logic                  p_valid;
  logic [AW-1:0]         p_addr;
  logic                  any_raised;
  logic [OPACITY_W-1:0]  prb_opacity;
  logic [HOLD_OUT_W-1:0] prb_hold;

  logic                  accept, issue, load_out;
  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [DW-1:0]         rd_data, wr_data;
  logic                  nb_ok;
  logic [AW-1:0]         nb_addr;

  logic [NORM_W-1:0]     mul_frac;
  logic [CFG_W-1:0]      mul_size;
  logic [PW-1:0]         prod;
  logic [CFG_W-1:0]      pix_raw, pix;

  logic [OPACITY_W-1:0]  new_opacity;
  logic [TIMER_BITS-1:0] new_hold;
  logic                  raised;

  logic [OPACITY_W-1:0]  res_opacity;
  logic [HOLD_OUT_W-1:0] res_hold;
  logic                  res_changed;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign time_in32 = 32'(s_tdata[NORM_W*2 +: TIME_IN_W]);

  // Grid size in use: zero reads as one, oversize as the maximum
  always_comb begin
    if (grid_width == '0) begin
      w = CFG_W'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w = CFG_W'(MAX_WIDTH);
    end else begin
      w = grid_width;
    end
    if (grid_height == '0) begin
      h = CFG_W'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h = CFG_W'(MAX_HEIGHT);
    end else begin
      h = grid_height;
    end
  end

  // Shared multiplier: maps x in MAPX, y in MAPY
  assign mul_frac = (state == ST_MAPX) ? in_x : in_y;
  assign mul_size = (state == ST_MAPX) ? w : h;
  assign prod     = PW'(mul_frac) * PW'(mul_size);
  assign pix_raw  = prod[NORM_W +: CFG_W];
  assign pix      = (pix_raw >= mul_size) ? (mul_size - CFG_W'(1)) : pix_raw;

  assign col_last = (col == w - CFG_W'(1));
  assign row_last = (row == h - CFG_W'(1));

  // Reveal neighbor select; off-grid neighbors are skipped
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = base_addr;
    case (slot)
      SLOT_CENTER: nb_ok = 1'b1;
      SLOT_RIGHT: begin
        nb_ok   = ((CFG_W+1)'(px) + (CFG_W+1)'(1)) < (CFG_W+1)'(w);
        nb_addr = base_addr + AW'(1);
      end
      SLOT_LEFT: begin
        nb_ok   = (px != '0);
        nb_addr = base_addr - AW'(1);
      end
      SLOT_DOWN: begin
        nb_ok   = ((CFG_W+1)'(py) + (CFG_W+1)'(1)) < (CFG_W+1)'(h);
        nb_addr = base_addr + ROW_STEP;
      end
      SLOT_UP: begin
        nb_ok   = (py != '0);
        nb_addr = base_addr - ROW_STEP;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and RAM read control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = base_addr;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser) inside
            OP_REVEAL, OP_PROBE: state_next = ST_MAPX;
            OP_TICK:             state_next = ST_TICK;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_MAPX: state_next = ST_MAPY;
      ST_MAPY: state_next = ST_ADDR;
      ST_ADDR: begin
        state_next = (in_op == OP_PROBE) ? ST_PRB_RD : ST_REVEAL;
      end
      ST_REVEAL: begin
        rd_en   = nb_ok;
        rd_addr = nb_addr;
        issue   = nb_ok;
        if (slot == SLOT_UP) begin
          state_next = ST_DRAIN;
        end
      end
      ST_TICK: begin
        rd_en   = 1'b1;
        rd_addr = row_base + AW'(col);
        issue   = 1'b1;
        if (col_last && row_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_PRB_RD: begin
        rd_en      = 1'b1;
        state_next = ST_PRB_WAIT;
      end
      ST_PRB_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Write port: clearing pass, else write-back of the pixel read in the cycle before
  assign wr_en   = (state == ST_CLEAR) || p_valid;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : p_addr;
  assign wr_data = (state == ST_CLEAR) ? {TIMER_BITS'(0), OPAQUE} : {new_hold, new_opacity};

  trfm_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  trfm_pix_unit #(
    .TIMER_BITS (TIMER_BITS)
  ) u_pix (
    .reveal      (in_op == OP_REVEAL),
    .hold_time   (in_time),
    .cur_opacity (rd_data[OPACITY_W-1:0]),
    .cur_hold    (rd_data[DW-1:OPACITY_W]),
    .new_opacity (new_opacity),
    .new_hold    (new_hold),
    .raised      (raised)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
      clr_addr    <= '0;
      p_valid     <= 1'b0;
      any_raised  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          CFG_GRID_HEIGHT: grid_height <= cfg_data;
          default:         grid_width  <= grid_width;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      p_valid <= issue;
      if (accept) begin
        any_raised <= 1'b0;
      end else if (p_valid && (in_op == OP_TICK) && raised) begin
        any_raised <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item registers, mapping, walk counters
  always_ff @(posedge clk) begin
    p_addr <= rd_addr;
    if (accept) begin
      in_op    <= s_tuser;
      in_x     <= s_tdata[0 +: NORM_W];
      in_y     <= s_tdata[NORM_W +: NORM_W];
      in_time  <= TIMER_BITS'((time_in32 > TIMER_MAX) ? TIMER_MAX : time_in32);
      slot     <= SLOT_CENTER;
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end
    if (state == ST_MAPX) begin
      px <= pix;
    end
    if (state == ST_MAPY) begin
      py <= pix;
    end
    if (state == ST_ADDR) begin
      base_addr <= AW'(32'(py) * MAX_WIDTH + 32'(px));
    end
    if (state == ST_REVEAL) begin
      slot <= slot + 3'd1;
    end
    if (state == ST_TICK) begin
      if (col_last) begin
        col      <= '0;
        row      <= row + CFG_W'(1);
        row_base <= row_base + ROW_STEP;
      end else begin
        col <= col + CFG_W'(1);
      end
    end
    if (state == ST_PRB_WAIT) begin
      prb_opacity <= rd_data[OPACITY_W-1:0];
      prb_hold    <= HOLD_OUT_W'(32'(rd_data[DW-1:OPACITY_W]));
    end
  end

  // Result fields per op
  always_comb begin
    res_opacity = '0;
    res_hold    = '0;
    res_changed = 1'b0;
    case (in_op)
      OP_REVEAL: res_changed = 1'b1;
      OP_PROBE: begin
        res_opacity = prb_opacity;
        res_hold    = prb_hold;
      end
      OP_TICK: res_changed = any_raised;
      default: res_changed = 1'b0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= M_TDATA_W'({res_changed, res_hold, res_opacity});
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_writing: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> !s_tready)
    else $error("item accepted with a write-back pending");

  a_walk_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK) |-> (col < w && row < h))
    else $error("tick walk left the grid in use");

  a_center_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REVEAL && slot == SLOT_CENTER) |=> p_valid)
    else $error("reveal center pixel not read");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("finished result left while output register full");
`endif

endmodule

### rtl/core/trfm_ram.sv
module trfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/trfm_pix_unit.sv
module trfm_pix_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           reveal,
  input  logic [TIMER_BITS-1:0]          hold_time,
  input  logic [trfm_pkg::OPACITY_W-1:0] cur_opacity,
  input  logic [TIMER_BITS-1:0]          cur_hold,
  output logic [trfm_pkg::OPACITY_W-1:0] new_opacity,
  output logic [TIMER_BITS-1:0]          new_hold,
  output logic                           raised
);

  import trfm_pkg::*;

  // Reveal clears and extends the hold; tick counts the hold down, then fades in
  always_comb begin
    new_opacity = cur_opacity;
    new_hold    = cur_hold;
    raised      = 1'b0;
    if (reveal) begin
      new_opacity = '0;
      if (hold_time > cur_hold) begin
        new_hold = hold_time;
      end
    end else if (cur_hold != '0) begin
      new_hold = cur_hold - TIMER_BITS'(1);
    end else if (cur_opacity != OPAQUE) begin
      new_opacity = cur_opacity + OPACITY_W'(1);
      raised      = 1'b1;
    end
  end

endmodule
